@@ hw/rtl/renc_pkg.sv @@
// Shared types and constants for the rotary encoder velocity decoder.
// Used by the channel interfaces, the front, queue and back stages, and the top level.
package renc_pkg;

  localparam int IDX_W      = 2;
  localparam int PIN_W      = 3;
  localparam int AB_W       = 2;
  localparam int SPIN_W     = 8;
  localparam int EVENT_W    = 2;
  localparam int MASK_W     = 3;
  localparam int TICK_W     = 8;
  localparam int GEAR_W     = 6;
  localparam int SUM_W      = 10;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pin bit positions inside a sample
  localparam int PIN_BTN = 2;

  localparam logic [AB_W-1:0]   AB_DETENT      = 2'b11;
  localparam logic [AB_W-1:0]   AB_ZERO        = 2'b00;
  localparam logic [AB_W-1:0]   AB_A_ONLY      = 2'b01;
  localparam logic [AB_W-1:0]   AB_B_ONLY      = 2'b10;
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [TICK_W-1:0] TICK_MAX       = 8'd255;
  localparam logic [TICK_W-1:0] GAP_FAST       = 8'd8;
  localparam logic [TICK_W-1:0] GAP_MID        = 8'd20;
  localparam logic [TICK_W-1:0] GAP_SLOW       = 8'd50;
  localparam logic [GEAR_W-1:0] GEAR_X50       = 6'd50;
  localparam logic [GEAR_W-1:0] GEAR_X10       = 6'd10;
  localparam logic [GEAR_W-1:0] GEAR_X2        = 6'd2;
  localparam logic [GEAR_W-1:0] GEAR_X1        = 6'd1;
  localparam logic signed [SUM_W-1:0] SPIN_MAX = 10'sd127;
  localparam logic signed [SUM_W-1:0] SPIN_MIN = -10'sd128;

  typedef enum logic [IDX_W-1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_READ_SPIN  = 2'd1,
    REQ_TAKE_EVENT = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSE_MASK   = 1'b0,
    REG_DEBOUNCE_TICKS = 1'b1
  } cfg_reg_e;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic             sample;
    logic             read_spin;
    logic             take_event;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [AB_W-1:0]  ab;
    logic             btn_up;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ hw/rtl/renc_if.sv @@
// Request and response channel interfaces of the encoder decoder.
// Widths come from renc_pkg.
interface renc_req_if;
  logic                        valid;
  logic                        ready;
  logic [renc_pkg::IDX_W-1:0]  req_type;
  logic [renc_pkg::IDX_W-1:0]  encoder_index;
  logic [renc_pkg::PIN_W-1:0]  pin_levels;

  modport source (output valid, req_type, encoder_index, pin_levels, input ready);
  modport sink   (input valid, req_type, encoder_index, pin_levels, output ready);
endinterface

interface renc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [renc_pkg::SPIN_W-1:0]  spin_value;
  logic [renc_pkg::EVENT_W-1:0]        press_event;
  logic                                button_pressed;

  modport source (output valid, spin_value, press_event, button_pressed, input ready);
  modport sink   (input valid, spin_value, press_event, button_pressed, output ready);
endinterface

@@ hw/rtl/renc_front.sv @@
// Front stage: accepts request items, decodes the request type, checks the
// encoder index and applies the A/B swap. Depends on renc_pkg and renc_req_if.
module renc_front #(
  parameter int ENCODER_COUNT = 3
) (
  renc_req_if.sink                   req,
  input  logic [renc_pkg::MASK_W-1:0] reverse_mask,
  input  renc_pkg::q_status_t        q_status,
  output logic                       push,
  output renc_pkg::item_t            push_item
);

  logic [renc_pkg::MASK_W-1:0] mask_shifted;
  logic [renc_pkg::AB_W-1:0]   ab_raw;
  logic                        swap;

  assign req.ready = !q_status.full;
  assign push      = req.valid && !q_status.full;

  assign ab_raw       = req.pin_levels[renc_pkg::AB_W-1:0];
  assign mask_shifted = reverse_mask >> req.encoder_index;
  // Swap only the single-channel levels; 00 and 11 read the same either way
  assign swap = mask_shifted[0] &&
                (ab_raw == renc_pkg::AB_A_ONLY || ab_raw == renc_pkg::AB_B_ONLY);

  always_comb begin
    push_item            = '0;
    push_item.idx        = req.encoder_index;
    push_item.in_range   = 32'(req.encoder_index) < ENCODER_COUNT;
    push_item.ab         = swap ? ~ab_raw : ab_raw;
    push_item.btn_up     = req.pin_levels[renc_pkg::PIN_BTN];
    case (req.req_type)
      renc_pkg::REQ_SAMPLE:     push_item.sample     = 1'b1;
      renc_pkg::REQ_READ_SPIN:  push_item.read_spin  = 1'b1;
      renc_pkg::REQ_TAKE_EVENT: push_item.take_event = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/renc_queue.sv @@
// Short queue of classified items between the front and back stages.
// Depends on renc_pkg.
module renc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  renc_pkg::item_t     push_item,
  input  logic                pop,
  output renc_pkg::item_t     head,
  output renc_pkg::q_status_t status
);

  renc_pkg::item_t               slots [renc_pkg::QUEUE_DEPTH];
  logic [renc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [renc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [renc_pkg::QCNT_W-1:0]   count;

  assign head         = slots[rd_ptr];
  assign status.empty = count == '0;
  assign status.full  = count == renc_pkg::QCNT_W'(renc_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/renc_back.sv @@
// Back stage: per-encoder state, edge machine, velocity gear, spin accumulator,
// button debounce and the output register. Depends on renc_pkg and renc_rsp_if.
module renc_back #(
  parameter int ENCODER_COUNT = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  renc_pkg::item_t               head,
  input  renc_pkg::q_status_t           q_status,
  input  logic [renc_pkg::TICK_W-1:0]   debounce_ticks,
  output logic                          pop,
  renc_rsp_if.source                    rsp
);

  logic [renc_pkg::AB_W-1:0]   prev_ab       [ENCODER_COUNT];
  logic                        cw_mark       [ENCODER_COUNT];
  logic                        ccw_mark      [ENCODER_COUNT];
  logic                        button_down   [ENCODER_COUNT];
  logic [renc_pkg::TICK_W-1:0] release_count [ENCODER_COUNT];
  logic [renc_pkg::SPIN_W-1:0] spin_total    [ENCODER_COUNT];
  logic [renc_pkg::TICK_W-1:0] gap_ticks     [ENCODER_COUNT];
  logic [renc_pkg::EVENT_W-1:0] pending_event;

  logic [renc_pkg::AB_W-1:0]   sel_prev;
  logic                        sel_cw;
  logic                        sel_ccw;
  logic                        sel_down;
  logic [renc_pkg::TICK_W-1:0] sel_rc;
  logic [renc_pkg::SPIN_W-1:0] sel_spin;
  logic [renc_pkg::TICK_W-1:0] sel_gap;

  logic                        step_up;
  logic                        step_dn;
  logic                        cw_next;
  logic                        ccw_next;
  logic [renc_pkg::GEAR_W-1:0] gear;
  logic signed [renc_pkg::SUM_W-1:0] delta;
  logic signed [renc_pkg::SUM_W-1:0] sum;
  logic [renc_pkg::SPIN_W-1:0] spin_next;
  logic [renc_pkg::TICK_W-1:0] gap_next;
  logic [renc_pkg::TICK_W-1:0] rc_next;
  logic                        down_next;
  logic                        press_new;
  logic                        do_sample;
  logic                        do_read;

  assign pop       = !q_status.empty && (!rsp.valid || rsp.ready);
  assign do_sample = head.sample && head.in_range;
  assign do_read   = head.read_spin && head.in_range;

  // Pick the addressed encoder's state
  always_comb begin
    sel_prev = renc_pkg::AB_DETENT;
    sel_cw   = 1'b0;
    sel_ccw  = 1'b0;
    sel_down = 1'b0;
    sel_rc   = '0;
    sel_spin = '0;
    sel_gap  = '0;
    for (int i = 0; i < ENCODER_COUNT; i++) begin
      if (int'(head.idx) == i) begin
        sel_prev = prev_ab[i];
        sel_cw   = cw_mark[i];
        sel_ccw  = ccw_mark[i];
        sel_down = button_down[i];
        sel_rc   = release_count[i];
        sel_spin = spin_total[i];
        sel_gap  = gap_ticks[i];
      end
    end
  end

  // Detent edge machine
  always_comb begin
    step_up  = 1'b0;
    step_dn  = 1'b0;
    cw_next  = sel_cw;
    ccw_next = sel_ccw;
    if (sel_prev == renc_pkg::AB_ZERO && head.ab == renc_pkg::AB_B_ONLY) begin
      step_dn  = !sel_ccw;
      cw_next  = 1'b0;
      ccw_next = 1'b0;
    end else if (sel_prev == renc_pkg::AB_ZERO && head.ab == renc_pkg::AB_A_ONLY) begin
      step_up  = !sel_cw;
      cw_next  = 1'b0;
      ccw_next = 1'b0;
    end else if (sel_prev == renc_pkg::AB_B_ONLY && head.ab == renc_pkg::AB_ZERO) begin
      ccw_next = 1'b1;
    end else if (sel_prev == renc_pkg::AB_A_ONLY && head.ab == renc_pkg::AB_ZERO) begin
      cw_next  = 1'b1;
    end
  end

  // Velocity gear and saturating spin
  always_comb begin
    if (sel_gap < renc_pkg::GAP_FAST) begin
      gear = renc_pkg::GEAR_X50;
    end else if (sel_gap < renc_pkg::GAP_MID) begin
      gear = renc_pkg::GEAR_X10;
    end else if (sel_gap < renc_pkg::GAP_SLOW) begin
      gear = renc_pkg::GEAR_X2;
    end else begin
      gear = renc_pkg::GEAR_X1;
    end
    delta = $signed({{(renc_pkg::SUM_W-renc_pkg::GEAR_W){1'b0}}, gear});
    if (step_dn) begin
      delta = -delta;
    end
    sum = $signed({{(renc_pkg::SUM_W-renc_pkg::SPIN_W){sel_spin[renc_pkg::SPIN_W-1]}},
                   sel_spin}) + delta;
    if (sum > renc_pkg::SPIN_MAX) begin
      spin_next = renc_pkg::SPIN_MAX[renc_pkg::SPIN_W-1:0];
    end else if (sum < renc_pkg::SPIN_MIN) begin
      spin_next = renc_pkg::SPIN_MIN[renc_pkg::SPIN_W-1:0];
    end else begin
      spin_next = sum[renc_pkg::SPIN_W-1:0];
    end
    if (step_up || step_dn) begin
      gap_next = '0;
    end else if (sel_gap != renc_pkg::TICK_MAX) begin
      gap_next = sel_gap + 1'b1;
    end else begin
      gap_next = sel_gap;
    end
  end

  // Button: press at once, release after the debounce count runs out
  always_comb begin
    rc_next   = sel_rc;
    down_next = sel_down;
    press_new = 1'b0;
    if (head.btn_up) begin
      if (sel_rc != '0) begin
        rc_next = sel_rc - 1'b1;
        if (sel_rc == renc_pkg::TICK_W'(1)) begin
          down_next = 1'b0;
        end
      end
    end else begin
      if (sel_rc == '0) begin
        down_next = 1'b1;
        press_new = 1'b1;
      end
      rc_next = debounce_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        prev_ab[i]       <= renc_pkg::AB_DETENT;
        cw_mark[i]       <= 1'b0;
        ccw_mark[i]      <= 1'b0;
        button_down[i]   <= 1'b0;
        release_count[i] <= '0;
        spin_total[i]    <= '0;
        gap_ticks[i]     <= '0;
      end
      pending_event <= '0;
    end else if (pop) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        if (int'(head.idx) == i) begin
          if (do_sample) begin
            prev_ab[i]       <= head.ab;
            cw_mark[i]       <= cw_next;
            ccw_mark[i]      <= ccw_next;
            button_down[i]   <= down_next;
            release_count[i] <= rc_next;
            gap_ticks[i]     <= gap_next;
            if (step_up || step_dn) begin
              spin_total[i] <= spin_next;
            end
          end else if (do_read) begin
            spin_total[i] <= '0;
          end
        end
      end
      if (do_sample && press_new) begin
        // Event code is encoder number plus one, wrapped to the field width
        pending_event <= renc_pkg::EVENT_W'(head.idx) + 1'b1;
      end else if (head.take_event) begin
        pending_event <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pop) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.spin_value     <= do_read ? sel_spin : '0;
      rsp.press_event    <= head.take_event ? pending_event : '0;
      rsp.button_pressed <= head.in_range && (do_sample ? down_next : sel_down);
    end
  end

endmodule

@@ hw/rtl/rotary_encoder_velocity_decoder_top.sv @@
// Rotary encoder bank with push buttons and velocity boost: top level.
// Depends on renc_pkg, renc_if, renc_front, renc_queue and renc_back.

// The block takes one request item per clock while its queue is not full and
// returns exactly one result item for each, in order. A request is classified at
// the input and held in a two-entry queue; while results are taken the back stage
// does one read-modify-write of the addressed encoder's state per cycle, so the
// sustained rate is one item per cycle, and a result is registered as its request
// leaves the queue. While results wait, up to two more requests are still accepted.
// reverse_mask and debounce_ticks are written through the register port and
// are to be changed only while no item is in flight.
module rotary_encoder_velocity_decoder_top #(
  parameter int ENCODER_COUNT = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  renc_req_if.sink                           req,
  renc_rsp_if.source                         rsp,
  input  logic                               write_enable,
  input  logic [renc_pkg::CFG_IDX_W-1:0]     reg_index,
  input  logic [renc_pkg::CFG_DATA_W-1:0]    write_data
);

  logic [renc_pkg::MASK_W-1:0] reverse_mask;
  logic [renc_pkg::TICK_W-1:0] debounce_ticks;

  logic                        push;
  logic                        pop;
  renc_pkg::item_t             push_item;
  renc_pkg::item_t             head;
  renc_pkg::q_status_t         q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_mask   <= '0;
      debounce_ticks <= renc_pkg::DEBOUNCE_RESET;
    end else if (write_enable) begin
      case (reg_index)
        renc_pkg::REG_REVERSE_MASK:   reverse_mask   <= write_data[renc_pkg::MASK_W-1:0];
        renc_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= write_data;
        default: ;
      endcase
    end
  end

  renc_front #(
    .ENCODER_COUNT (ENCODER_COUNT)
  ) u_front (
    .req          (req),
    .reverse_mask (reverse_mask),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  renc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  renc_back #(
    .ENCODER_COUNT (ENCODER_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .debounce_ticks (debounce_ticks),
    .pop            (pop),
    .rsp            (rsp)
  );

  a_rst_clears_output: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid right after reset");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> rsp.valid)
    else $error("dequeued item produced no result");

  a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !pop)
    else $error("item dequeued while result held");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (q_status.full && !pop) |=> !(q_status.empty))
    else $error("queue lost an item while full");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for rotary_encoder_velocity_decoder_top: predicts every result
// item from a behavioral copy of the encoder bank and compares field by field.
// Depends on renc_pkg and the renc_req_if / renc_rsp_if channel interfaces.
module tb_top;

  localparam int ENC_N = 3;
  localparam logic [renc_pkg::IDX_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [renc_pkg::IDX_W-1:0] kind;
    logic [renc_pkg::IDX_W-1:0] idx;
    logic [renc_pkg::PIN_W-1:0] pins;
  } stim_t;

  typedef struct packed {
    logic signed [renc_pkg::SPIN_W-1:0] spin;
    logic [renc_pkg::EVENT_W-1:0]       press;
    logic                               btn;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            drv_valid = 1'b0;
  logic [renc_pkg::IDX_W-1:0]      drv_kind  = '0;
  logic [renc_pkg::IDX_W-1:0]      drv_idx   = '0;
  logic [renc_pkg::PIN_W-1:0]      drv_pins  = '0;
  logic                            drv_ready = 1'b0;
  logic                            req_taken = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [renc_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [renc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  renc_req_if req_ch ();
  renc_rsp_if rsp_ch ();

  assign req_ch.valid         = drv_valid;
  assign req_ch.req_type      = drv_kind;
  assign req_ch.encoder_index = drv_idx;
  assign req_ch.pin_levels    = drv_pins;
  assign rsp_ch.ready         = drv_ready;

  rotary_encoder_velocity_decoder_top #(
    .ENCODER_COUNT(ENC_N)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .write_enable (cfg_we),
    .reg_index    (cfg_idx),
    .write_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the encoder bank
  logic [renc_pkg::MASK_W-1:0]        rev_mask;
  logic [renc_pkg::TICK_W-1:0]        debounce_len;
  logic [renc_pkg::AB_W-1:0]          enc_prev_ab     [ENC_N];
  logic                               enc_cw_mark     [ENC_N];
  logic                               enc_ccw_mark    [ENC_N];
  logic                               enc_btn_down    [ENC_N];
  logic [renc_pkg::TICK_W-1:0]        enc_release_cnt [ENC_N];
  logic signed [renc_pkg::SPIN_W-1:0] enc_spin        [ENC_N];
  logic [renc_pkg::TICK_W-1:0]        enc_gap         [ENC_N];
  logic [renc_pkg::EVENT_W-1:0]       press_latch;

  stim_t    request_queue[$];
  readout_t pending_readouts[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_total = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int fail_count = 0;
  int sat_hits = 0;
  int gear_hits [4];

  // Generator view of each encoder's shaft position, index 3 included for noise
  logic [renc_pkg::AB_W-1:0] quad_seq [4] = '{renc_pkg::AB_DETENT, renc_pkg::AB_A_ONLY,
                                             renc_pkg::AB_ZERO, renc_pkg::AB_B_ONLY};
  int gen_pos [4];

  function automatic readout_t decode_request(logic [renc_pkg::IDX_W-1:0] kind,
                                              logic [renc_pkg::IDX_W-1:0] idx,
                                              logic [renc_pkg::PIN_W-1:0] pins);
    readout_t r;
    logic in_range;
    logic [renc_pkg::AB_W-1:0] ab;
    int step;
    int gear;
    int sum;
    r = '0;
    in_range = (idx < ENC_N);
    case (kind)
      renc_pkg::REQ_SAMPLE: begin
        if (in_range) begin
          ab = pins[renc_pkg::AB_W-1:0];
          step = 0;
          if (rev_mask[idx] && (ab == renc_pkg::AB_A_ONLY || ab == renc_pkg::AB_B_ONLY))
            ab = ~ab;
          if (enc_prev_ab[idx] == renc_pkg::AB_ZERO && ab == renc_pkg::AB_B_ONLY) begin
            if (!enc_ccw_mark[idx]) step = -1;
            enc_cw_mark[idx] = 1'b0;
            enc_ccw_mark[idx] = 1'b0;
          end else if (enc_prev_ab[idx] == renc_pkg::AB_ZERO &&
                       ab == renc_pkg::AB_A_ONLY) begin
            if (!enc_cw_mark[idx]) step = 1;
            enc_cw_mark[idx] = 1'b0;
            enc_ccw_mark[idx] = 1'b0;
          end else if (enc_prev_ab[idx] == renc_pkg::AB_B_ONLY &&
                       ab == renc_pkg::AB_ZERO) begin
            enc_ccw_mark[idx] = 1'b1;
          end else if (enc_prev_ab[idx] == renc_pkg::AB_A_ONLY &&
                       ab == renc_pkg::AB_ZERO) begin
            enc_cw_mark[idx] = 1'b1;
          end
          if (step != 0) begin
            if (enc_gap[idx] < renc_pkg::GAP_FAST) begin
              gear = 50;
              gear_hits[0]++;
            end else if (enc_gap[idx] < renc_pkg::GAP_MID) begin
              gear = 10;
              gear_hits[1]++;
            end else if (enc_gap[idx] < renc_pkg::GAP_SLOW) begin
              gear = 2;
              gear_hits[2]++;
            end else begin
              gear = 1;
              gear_hits[3]++;
            end
            sum = int'(enc_spin[idx]) + step * gear;
            if (sum > 127 || sum < -128) sat_hits++;
            if (sum > 127) sum = 127;
            if (sum < -128) sum = -128;
            enc_spin[idx] = 8'(sum);
            enc_gap[idx] = '0;
          end else if (enc_gap[idx] != renc_pkg::TICK_MAX) begin
            enc_gap[idx] = enc_gap[idx] + 8'd1;
          end
          enc_prev_ab[idx] = ab;
          if (pins[renc_pkg::PIN_BTN]) begin
            if (enc_release_cnt[idx] != 0) begin
              enc_release_cnt[idx] = enc_release_cnt[idx] - 8'd1;
              if (enc_release_cnt[idx] == 0) enc_btn_down[idx] = 1'b0;
            end
          end else begin
            // a fresh press latches the event; held presses only reload the count
            if (enc_release_cnt[idx] == 0) begin
              enc_btn_down[idx] = 1'b1;
              press_latch = idx + 2'd1;
            end
            enc_release_cnt[idx] = debounce_len;
          end
        end
      end
      renc_pkg::REQ_READ_SPIN: begin
        if (in_range) begin
          r.spin = enc_spin[idx];
          enc_spin[idx] = '0;
        end
      end
      renc_pkg::REQ_TAKE_EVENT: begin
        r.press = press_latch;
        press_latch = '0;
      end
      default: ;
    endcase
    r.btn = in_range ? enc_btn_down[idx] : 1'b0;
    return r;
  endfunction

  task automatic queue_req(input logic [renc_pkg::IDX_W-1:0] kind, input int idx,
                           input logic [renc_pkg::PIN_W-1:0] pins);
    stim_t s;
    s.kind = kind;
    s.idx = idx[renc_pkg::IDX_W-1:0];
    s.pins = pins;
    request_queue.push_back(s);
    queued_total++;
  endtask

  // Mostly well-formed shaft motion and button activity, plus reads and noise
  task automatic fill_random(input int count);
    int goal;
    int pick;
    int k;
    int hold;
    int dir;
    logic up;
    goal = queued_total + count;
    while (queued_total < goal) begin
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, ENC_N - 1);
      up = ($urandom_range(0, 7) != 0);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       hold = $urandom_range(48, 56);
          1:       hold = $urandom_range(16, 30);
          2, 3:    hold = $urandom_range(4, 12);
          default: hold = 0;
        endcase
        repeat (hold) queue_req(renc_pkg::REQ_SAMPLE, k, {up, quad_seq[gen_pos[k]]});
        dir = $urandom_range(0, 1) ? 1 : 3;
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0) dir = 4 - dir;
          gen_pos[k] = (gen_pos[k] + dir) % 4;
          queue_req(renc_pkg::REQ_SAMPLE, k, {up, quad_seq[gen_pos[k]]});
        end
      end else if (pick < 70) begin
        queue_req(renc_pkg::REQ_READ_SPIN, k, renc_pkg::PIN_W'($urandom_range(0, 7)));
      end else if (pick < 80) begin
        queue_req(renc_pkg::REQ_TAKE_EVENT, k, renc_pkg::PIN_W'($urandom_range(0, 7)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3))
          queue_req(renc_pkg::REQ_SAMPLE, k, {1'b0, quad_seq[gen_pos[k]]});
        repeat ($urandom_range(0, 12))
          queue_req(renc_pkg::REQ_SAMPLE, k, {1'b1, quad_seq[gen_pos[k]]});
      end else begin
        queue_req(renc_pkg::IDX_W'($urandom_range(0, 3)), $urandom_range(0, 3),
                  renc_pkg::PIN_W'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic write_settings(input logic [renc_pkg::MASK_W-1:0] mask,
                                input logic [renc_pkg::TICK_W-1:0] ticks);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= renc_pkg::REG_REVERSE_MASK;
    cfg_data <= renc_pkg::CFG_DATA_W'(mask);
    @(negedge clk);
    cfg_idx <= renc_pkg::REG_DEBOUNCE_TICKS;
    cfg_data <= ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
    rev_mask = mask;
    debounce_len = ticks;
  endtask

  // Hold off until every item has been taken and answered, then let the pipe settle
  task automatic wait_drained();
    while (request_queue.size() != 0 || drv_valid || pending_readouts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive_req
    stim_t nxt;
    if (!rst) begin
      if (!drv_valid || req_taken) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          drv_valid <= 1'b1;
          drv_kind <= nxt.kind;
          drv_idx <= nxt.idx;
          drv_pins <= nxt.pins;
        end else begin
          drv_valid <= 1'b0;
        end
      end
      drv_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_rsp
    readout_t got;
    readout_t want;
    req_taken <= req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.spin = rsp_ch.spin_value;
        got.press = rsp_ch.press_event;
        got.btn = rsp_ch.button_pressed;
        n_checked++;
        if (pending_readouts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result with nothing pending: spin %0d press %0d btn %0b",
                     $realtime, got.spin, got.press, got.btn);
        end else begin
          want = pending_readouts.pop_front();
          if (got.spin !== want.spin || got.press !== want.press || got.btn !== want.btn) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: spin %0d/%0d press %0d/%0d btn %0b/%0b (exp/got)",
                       $realtime, want.spin, got.spin, want.press, got.press,
                       want.btn, got.btn);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        n_accepted++;
        pending_readouts.push_back(decode_request(req_ch.req_type, req_ch.encoder_index,
                                                  req_ch.pin_levels));
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rev_mask = '0;
    debounce_len = renc_pkg::DEBOUNCE_RESET;
    press_latch = '0;
    for (int i = 0; i < ENC_N; i++) begin
      enc_prev_ab[i] = renc_pkg::AB_DETENT;
      enc_cw_mark[i] = 1'b0;
      enc_ccw_mark[i] = 1'b0;
      enc_btn_down[i] = 1'b0;
      enc_release_cnt[i] = '0;
      enc_spin[i] = '0;
      enc_gap[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      gen_pos[i] = 0;
      gear_hits[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, both step directions, mark suppression, press,
    // out-of-range index and the unused request type
    queue_req(renc_pkg::REQ_READ_SPIN, 0, 3'b000);
    queue_req(renc_pkg::REQ_TAKE_EVENT, 0, 3'b111);
    queue_req(renc_pkg::REQ_SAMPLE, 0, {1'b1, renc_pkg::AB_B_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 0, {1'b1, renc_pkg::AB_ZERO});
    queue_req(renc_pkg::REQ_SAMPLE, 0, {1'b1, renc_pkg::AB_A_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 0, {1'b1, renc_pkg::AB_DETENT});
    queue_req(renc_pkg::REQ_SAMPLE, 1, {1'b1, renc_pkg::AB_A_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 1, {1'b1, renc_pkg::AB_ZERO});
    queue_req(renc_pkg::REQ_SAMPLE, 1, {1'b1, renc_pkg::AB_B_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 1, {1'b1, renc_pkg::AB_DETENT});
    queue_req(renc_pkg::REQ_SAMPLE, 2, {1'b1, renc_pkg::AB_A_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 2, {1'b1, renc_pkg::AB_ZERO});
    queue_req(renc_pkg::REQ_SAMPLE, 2, {1'b1, renc_pkg::AB_A_ONLY});
    queue_req(renc_pkg::REQ_SAMPLE, 2, {1'b0, renc_pkg::AB_DETENT});
    queue_req(renc_pkg::REQ_TAKE_EVENT, 1, 3'b000);
    queue_req(renc_pkg::REQ_READ_SPIN, 0, 3'b111);
    queue_req(renc_pkg::REQ_READ_SPIN, 1, 3'b000);
    queue_req(renc_pkg::REQ_SAMPLE, 3, 3'b000);
    queue_req(renc_pkg::REQ_READ_SPIN, 3, 3'b111);
    queue_req(renc_pkg::REQ_TAKE_EVENT, 3, 3'b000);
    queue_req(REQ_UNUSED, 2, 3'b111);
    for (int i = 0; i < ENC_N; i++) gen_pos[i] = 2;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_settings(3'b000, 8'd1);
        1:       write_settings(3'b111, 8'd255);
        2:       write_settings(3'b101, 8'd3);
        3:       write_settings(3'b010, 8'd0);
        default: write_settings(renc_pkg::MASK_W'($urandom_range(0, 7)),
                                renc_pkg::TICK_W'($urandom_range(1, 10)));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      fill_random(120);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d items, %0d results checked, 8 register settings, 4 idle profiles.",
             n_accepted, n_checked);
    $display("Steps by gear x50/x10/x2/x1: %0d/%0d/%0d/%0d, saturated steps: %0d.",
             gear_hits[0], gear_hits[1], gear_hits[2], gear_hits[3], sat_hits);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failing results", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
